/* sv/assert_macros.svh */
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checks a property on every rising clock edge, except while reset is asserted.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

/* sv/itp_pkg.sv */
// Shared types, codes and token functions for the infix to postfix converter.
package itp_pkg;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_POW  = 3'd4,
		OP_OPEN = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_BAD_CHAR   = 3'd1,
		ERR_OPEN_CLOSE = 3'd2,
		ERR_LEFT_OPEN  = 3'd3,
		ERR_OVERFLOW   = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		OUT_SPACE = 2'd0,
		OUT_TOKEN = 2'd1,
		OUT_FINAL = 2'd2
	} out_sel_t;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Controller to datapath commands
	typedef struct packed {
		logic     load_in;
		logic     pop;
		logic     push;
		logic     set_err;
		err_t     err;
		logic     set_inside;
		logic     clr_inside;
		logic     load_tok;
		logic     tok_from_top;
		logic     out_load;
		out_sel_t out_sel;
		logic     clear_all;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_end;
		logic err_pending;
		logic is_digit;
		logic is_space;
		logic is_open;
		logic is_close;
		logic is_op;
		logic count_zero;
		logic count_full;
		logic top_is_open;
		logic top_pops;
		logic in_number;
		logic anything;
		logic out_free;
	} sts_t;

	function automatic logic [7:0] op_char(input op_t op);
		logic [7:0] c;
		case (op)
			OP_ADD:  c = CH_PLUS;
			OP_SUB:  c = CH_MINUS;
			OP_MUL:  c = CH_STAR;
			OP_DIV:  c = CH_SLASH;
			OP_POW:  c = CH_CARET;
			OP_OPEN: c = CH_OPEN;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// 0 marks "no precedence" (open paren, unused codes)
	function automatic logic [1:0] op_prec(input op_t op);
		logic [1:0] p;
		case (op)
			OP_ADD, OP_SUB: p = 2'd1;
			OP_MUL, OP_DIV: p = 2'd2;
			OP_POW:         p = 2'd3;
			default:        p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic op_t op_of_char(input logic [7:0] c);
		op_t op;
		case (c)
			CH_PLUS:  op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_STAR:  op = OP_MUL;
			CH_SLASH: op = OP_DIV;
			CH_CARET: op = OP_POW;
			CH_OPEN:  op = OP_OPEN;
			default:  op = OP_ADD;
		endcase
		return op;
	endfunction

	// Stacked operator leaves before the incoming one; ^ is right-associative
	function automatic logic pops_before(input op_t top, input op_t inc);
		logic [1:0] p1;
		logic [1:0] p2;
		logic       r;
		p1 = op_prec(top);
		p2 = op_prec(inc);
		if (p1 == 2'd0 || p2 == 2'd0) begin
			r = 1'b0;
		end else if (inc == OP_POW) begin
			r = p1 > p2;
		end else begin
			r = p1 >= p2;
		end
		return r;
	endfunction

endpackage

/* sv/itp_dp.sv */
// Datapath: input latch, character decode, operator stack, flags and output register.
module itp_dp #(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  itp_pkg::cmd_t      cmd,
	output itp_pkg::sts_t      sts,
	input  logic [7:0]         in_char,
	input  logic               in_end,
	output logic               m_valid,
	input  logic               m_ready,
	output logic [15:0]        m_data,
	output logic               m_last
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(STACK_DEPTH);

	logic [7:0]         char_q;
	logic               end_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_m1;
	logic               inside_q;
	logic               any_q;
	itp_pkg::err_t      err_q;
	logic [7:0]         tok_q;
	itp_pkg::op_t       stack_q [STACK_DEPTH];
	itp_pkg::op_t       top;
	itp_pkg::op_t       in_op;
	logic               out_valid_q;
	logic [7:0]         out_char_q;
	logic               out_has_q;
	logic               out_last_q;
	itp_pkg::err_t      out_err_q;
	logic               out_free;

	assign cnt_m1   = cnt_q - 1'b1;
	assign top      = stack_q[cnt_m1[IW-1:0]];
	assign in_op    = itp_pkg::op_of_char(char_q);
	assign out_free = !out_valid_q || m_ready;

	always_comb begin
		sts             = '0;
		sts.is_end      = end_q;
		sts.err_pending = err_q != itp_pkg::ERR_NONE;
		sts.is_digit    = char_q >= itp_pkg::CH_ZERO && char_q <= itp_pkg::CH_NINE;
		sts.is_space    = char_q == itp_pkg::CH_SPACE
			|| (char_q >= itp_pkg::CH_TAB && char_q <= itp_pkg::CH_CR);
		sts.is_open     = char_q == itp_pkg::CH_OPEN;
		sts.is_close    = char_q == itp_pkg::CH_CLOSE;
		sts.is_op       = char_q == itp_pkg::CH_PLUS || char_q == itp_pkg::CH_MINUS
			|| char_q == itp_pkg::CH_STAR || char_q == itp_pkg::CH_SLASH
			|| char_q == itp_pkg::CH_CARET;
		sts.count_zero  = cnt_q == '0;
		sts.count_full  = cnt_q == CW'(STACK_DEPTH);
		sts.top_is_open = top == itp_pkg::OP_OPEN;
		sts.top_pops    = itp_pkg::pops_before(top, in_op);
		sts.in_number   = inside_q;
		sts.anything    = any_q;
		sts.out_free    = out_free;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			inside_q    <= 1'b0;
			any_q       <= 1'b0;
			err_q       <= itp_pkg::ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.pop) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.set_inside) begin
				inside_q <= 1'b1;
			end else if (cmd.clr_inside) begin
				inside_q <= 1'b0;
			end
			if (cmd.set_err) begin
				err_q <= cmd.err;
			end
			if (cmd.out_load && cmd.out_sel == itp_pkg::OUT_TOKEN) begin
				any_q <= 1'b1;
			end
			if (cmd.clear_all) begin
				cnt_q    <= '0;
				inside_q <= 1'b0;
				any_q    <= 1'b0;
				err_q    <= itp_pkg::ERR_NONE;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			char_q <= in_char;
			end_q  <= in_end;
		end
		if (cmd.push) begin
			stack_q[cnt_q[IW-1:0]] <= in_op;
		end
		if (cmd.load_tok) begin
			tok_q <= cmd.tok_from_top ? itp_pkg::op_char(top) : char_q;
		end
		if (cmd.out_load) begin
			case (cmd.out_sel)
				itp_pkg::OUT_SPACE: begin
					out_char_q <= itp_pkg::CH_SPACE;
					out_has_q  <= 1'b1;
					out_last_q <= 1'b0;
					out_err_q  <= itp_pkg::ERR_NONE;
				end
				itp_pkg::OUT_TOKEN: begin
					out_char_q <= tok_q;
					out_has_q  <= 1'b1;
					out_last_q <= 1'b0;
					out_err_q  <= itp_pkg::ERR_NONE;
				end
				default: begin
					out_char_q <= 8'h00;
					out_has_q  <= 1'b0;
					out_last_q <= 1'b1;
					out_err_q  <= err_q;
				end
			endcase
		end
	end

	assign m_valid = out_valid_q;
	assign m_data  = {4'b0000, out_err_q, out_has_q, out_char_q};
	assign m_last  = out_last_q;

endmodule

/* sv/itp_ctrl.sv */
// Controller: one-hot sequencer for decode, stack pop loops and byte emission.
module itp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_valid,
	output logic          s_ready,
	input  itp_pkg::sts_t sts,
	output itp_pkg::cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_OPLOOP = 8'b0000_0100,
		S_CLOSE  = 8'b0000_1000,
		S_FLUSH  = 8'b0001_0000,
		S_SPACE  = 8'b0010_0000,
		S_TOKEN  = 8'b0100_0000,
		S_FINAL  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	state_t ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	assign s_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = '0;
		cmd.err = itp_pkg::ERR_NONE;
		case (state_q)
			S_IDLE: begin
				if (s_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_end) begin
					state_d = sts.err_pending ? S_FINAL : S_FLUSH;
				end else if (sts.err_pending) begin
					state_d = S_IDLE;
				end else if (sts.is_digit) begin
					cmd.set_inside = 1'b1;
					cmd.load_tok   = 1'b1;
					ret_d          = S_IDLE;
					state_d        = (!sts.in_number && sts.anything) ? S_SPACE : S_TOKEN;
				end else begin
					cmd.clr_inside = 1'b1;
					state_d        = S_IDLE;
					if (sts.is_space) begin
						state_d = S_IDLE;
					end else if (sts.is_open) begin
						if (sts.count_full) begin
							cmd.set_err = 1'b1;
							cmd.err     = itp_pkg::ERR_OVERFLOW;
						end else begin
							cmd.push = 1'b1;
						end
					end else if (sts.is_close) begin
						state_d = S_CLOSE;
					end else if (sts.is_op) begin
						state_d = S_OPLOOP;
					end else begin
						cmd.set_err = 1'b1;
						cmd.err     = itp_pkg::ERR_BAD_CHAR;
					end
				end
			end
			S_OPLOOP: begin
				if (!sts.count_zero && sts.top_pops) begin
					cmd.pop          = 1'b1;
					cmd.load_tok     = 1'b1;
					cmd.tok_from_top = 1'b1;
					ret_d            = S_OPLOOP;
					state_d          = sts.anything ? S_SPACE : S_TOKEN;
				end else begin
					if (sts.count_full) begin
						cmd.set_err = 1'b1;
						cmd.err     = itp_pkg::ERR_OVERFLOW;
					end else begin
						cmd.push = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_CLOSE: begin
				if (sts.count_zero) begin
					cmd.set_err = 1'b1;
					cmd.err     = itp_pkg::ERR_OPEN_CLOSE;
					state_d     = S_IDLE;
				end else begin
					cmd.pop = 1'b1;
					if (sts.top_is_open) begin
						state_d = S_IDLE;
					end else begin
						cmd.load_tok     = 1'b1;
						cmd.tok_from_top = 1'b1;
						ret_d            = S_CLOSE;
						state_d          = sts.anything ? S_SPACE : S_TOKEN;
					end
				end
			end
			S_FLUSH: begin
				if (sts.count_zero) begin
					state_d = S_FINAL;
				end else begin
					cmd.pop = 1'b1;
					if (sts.top_is_open) begin
						cmd.set_err = 1'b1;
						cmd.err     = itp_pkg::ERR_LEFT_OPEN;
						state_d     = S_FINAL;
					end else begin
						cmd.load_tok     = 1'b1;
						cmd.tok_from_top = 1'b1;
						ret_d            = S_FLUSH;
						state_d          = sts.anything ? S_SPACE : S_TOKEN;
					end
				end
			end
			S_SPACE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = itp_pkg::OUT_SPACE;
					state_d      = S_TOKEN;
				end
			end
			S_TOKEN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = itp_pkg::OUT_TOKEN;
					state_d      = ret_q;
				end
			end
			S_FINAL: begin
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_sel   = itp_pkg::OUT_FINAL;
					cmd.clear_all = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* sv/infix_to_postfix_converter.sv */
// Top level of the streaming shunting-yard infix to postfix converter.
//
//  channel  | dir | tdata (low bit up)                          | tlast / tuser
//  s_axis   | in  | [7:0] in_char                               | tlast = end_of_expr
//  m_axis   | out | [7:0] out_char, [8] has_char, [11:9] error  | tlast = last
//
//  Each input transaction is taken in the idle state and decoded in the next
//  cycle. Each pop reads the stack top, then emits a space if anything went
//  out before and the token; an operator or ')' ends with a closing step
//  (push, pop of '(' or error). The end marker flushes the stack, a '(' on
//  it being an error, then sends the final transaction, at once if an error
//  is pending. The single operator stack read port sets the pop pace.
//  arst_n clears the controller, stack count, flags and the output valid flag.
//  A stalled m_axis holds the sequencer in its emit state; the output register
//  still lets one finished byte wait while the next one is being prepared.
`include "assert_macros.svh"

module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_char
	input  logic        s_axis_tlast,  // end_of_expr
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] out_char, [8] has_char, [11:9] error_code
	output logic        m_axis_tlast   // last
);

	itp_pkg::cmd_t cmd;
	itp_pkg::sts_t sts;
	itp_pkg::err_t out_err;

	assign out_err = itp_pkg::err_t'(m_axis_tdata[11:9]);

	// Sequencer: one transaction at a time, pop loops and byte emission
	itp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Stack, flags and output register
	itp_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_char (s_axis_tdata),
		.in_end  (s_axis_tlast),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_data  (m_axis_tdata),
		.m_last  (m_axis_tlast)
	);

	// A push is never issued on a full stack
	`ASSERT_NEVER(a_push_full, clk, arst_n, cmd.push && sts.count_full)
	// The final transaction never carries a byte
	`ASSERT_PROP(a_last_nochar, clk, arst_n, m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[8])
	// Error codes only travel on the final transaction
	`ASSERT_PROP(a_err_last, clk, arst_n, m_axis_tvalid && !m_axis_tlast |-> out_err == itp_pkg::ERR_NONE)
	// Emission is only commanded when the output register can take it
	`ASSERT_NEVER(a_out_overrun, clk, arst_n, cmd.out_load && !sts.out_free)

endmodule
